[rtl/core/dcsc_pkg.sv]
// Shared types and constants for the distance cruise speed control block.
`timescale 1ns / 1ps

package dcsc_pkg;

    localparam int unsigned SPEED_W    = 7;
    localparam int unsigned DIST_W     = 10;
    localparam int unsigned COUNT_W    = 3;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 8;
    localparam int unsigned S_DATA_W   = 16;
    localparam int unsigned M_DATA_W   = 16;

    localparam logic [SPEED_W-1:0] SAFE_DIST_RST = 7'd55;
    localparam logic [SPEED_W-1:0] MAX_SPEED_RST = 7'd80;
    localparam logic [SPEED_W-1:0] DEAD_DIST_RST = 7'd10;

    localparam logic [SPEED_W-1:0] RAMP_INC   = 7'd20;
    localparam logic [SPEED_W-1:0] SPEED_SAT  = 7'd127;
    localparam logic [SPEED_W-1:0] REPORT_MIN = 7'd12;
    localparam logic [COUNT_W-1:0] SAFE_LIMIT = 3'd5;
    localparam int unsigned        StepCm     = 10;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SAFE_DIST = 2'd0,
        REG_MAX_SPEED = 2'd1,
        REG_DEAD_DIST = 2'd2,
        REG_UNUSED    = 2'd3
    } cfg_idx_t;

    typedef struct packed {
        logic [SPEED_W-1:0] safe_dist;
        logic [SPEED_W-1:0] speed_cap;
        logic [SPEED_W-1:0] dead_distance;
    } cfg_t;

    typedef struct packed {
        logic [SPEED_W-1:0] speed;
        logic [DIST_W-1:0]  last_distance;
        logic [COUNT_W-1:0] safe_count;
        logic               seen_first;
    } ctl_state_t;

    typedef struct packed {
        logic [SPEED_W-1:0] reported_speed;
        logic               speed_changed;
        logic               stopped;
        logic [SPEED_W-1:0] speed_pwm;
    } result_t;

endpackage

[rtl/core/distance_cruise_speed_control.sv]
// Top level of the distance cruise speed control block.
`timescale 1ns / 1ps
//
//  Channel | Direction | Beat contents
//  --------+-----------+------------------------------------------------------
//  s_      | in        | tdata: distance [9:0], zero [15:10]
//  m_      | out       | tdata: speed_pwm [6:0], stopped [7], speed_changed [8],
//          |           |        reported_speed [15:9]
//  cfg_    | in        | index 0 safe distance, 1 speed cap, 2 dead distance
//
//  One sample per cycle, sustained while m_tready stays high. A beat is held
//  in the input register, is resolved by the update logic and lands in the
//  result register.
//  The speed state is updated by the same edge that loads the result, so each
//  sample sees the state left by the one before it with no gap.
//  Reset (aresetn low, synchronous) clears speed, last distance, safe count and
//  the first-sample flag, empties both registers and restores register defaults.
//  When m_tready is low and a result waits, the input register takes a beat
//  only if it is empty; after that s_tready drops until the result is taken.

module distance_cruise_speed_control
    import dcsc_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_DATA_W-1:0]   s_tdata,   // distance [9:0], zero fill above

    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_DATA_W-1:0]   m_tdata,   // speed_pwm, stopped, speed_changed,
                                             // reported_speed (low bit up)

    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t              cfg;
    ctl_state_t        state_reg;
    ctl_state_t        state_next;
    result_t           result_next;
    result_t           result_reg;
    logic              in_valid_reg;
    logic [DIST_W-1:0] dist_reg;
    logic              out_valid_reg;
    logic              advance;

    dcsc_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    dcsc_calc u_calc (
        .distance (dist_reg),
        .cfg      (cfg),
        .cur      (state_reg),
        .nxt      (state_next),
        .res      (result_next)
    );

    // advance the held sample whenever the result register is free or draining
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || !out_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    // input payload needs no reset
    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            dist_reg <= s_tdata[DIST_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            state_reg     <= state_next;
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            // drop the result once taken
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            result_reg <= result_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = result_reg;

endmodule

[rtl/core/dcsc_cfg.sv]
// Configuration register file: safe distance, maximum speed, dead distance.
`timescale 1ns / 1ps

module dcsc_cfg
    import dcsc_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.safe_dist     <= SAFE_DIST_RST;
            cfg_reg.speed_cap     <= MAX_SPEED_RST;
            cfg_reg.dead_distance <= DEAD_DIST_RST;
        end else if (cfg_valid) begin
            case (cfg_idx_t'(cfg_index))
                REG_SAFE_DIST: cfg_reg.safe_dist     <= cfg_data[SPEED_W-1:0];
                REG_MAX_SPEED: cfg_reg.speed_cap     <= cfg_data[SPEED_W-1:0];
                REG_DEAD_DIST: cfg_reg.dead_distance <= cfg_data[SPEED_W-1:0];
                default: ;
            endcase
        end
    end

endmodule

[rtl/core/dcsc_calc.sv]
// Per-sample speed update: zone decision, ramp, slowdown step and report clamp.
`timescale 1ns / 1ps

module dcsc_calc
    import dcsc_pkg::*;
(
    input  logic [DIST_W-1:0] distance,
    input  cfg_t              cfg,
    input  ctl_state_t        cur,
    output ctl_state_t        nxt,
    output result_t           res
);

    // divide by ten as multiply by 205 and shift by 11; exact for the gap range here
    localparam logic [7:0]  STEP_RECIP = 8'd205;
    localparam int unsigned STEP_SHIFT = 11;

    always_comb begin
        logic [SPEED_W-1:0] spd;
        logic [SPEED_W-1:0] gap;
        logic [7:0]         gap_up;
        logic [15:0]        quot;
        logic [3:0]         step;
        logic [5:0]         dec;
        logic [COUNT_W-1:0] cnt;
        logic [SPEED_W:0]   ramp;
        logic               stop;

        spd    = cur.speed;
        cnt    = cur.safe_count;
        stop   = 1'b0;
        gap    = cfg.safe_dist - distance[SPEED_W-1:0];
        gap_up = {1'b0, gap} + 8'(StepCm - 1);
        quot   = {8'b0, gap_up} * {8'b0, STEP_RECIP};
        step   = quot[STEP_SHIFT +: 4];
        ramp   = {1'b0, cur.speed} + {1'b0, RAMP_INC};
        if (cur.seen_first && (distance > cur.last_distance)) begin
            dec = {1'b0, step, 1'b0};
        end else begin
            dec = {2'b00, step} + {1'b0, step, 1'b0};
        end

        if (distance <= {3'b000, cfg.dead_distance}) begin
            // dead zone: stop at once
            spd  = '0;
            stop = 1'b1;
        end else if (distance >= {3'b000, cfg.safe_dist}) begin
            cnt = cur.safe_count + 3'd1;
            if (cnt > SAFE_LIMIT) begin
                cnt = '0;
                if (cur.speed < cfg.speed_cap) begin
                    spd = ramp[SPEED_W] ? SPEED_SAT : ramp[SPEED_W-1:0];
                end else begin
                    spd = cfg.speed_cap;
                end
            end
        end else begin
            // between zones: distance < safe, so gap fits seven bits
            spd = ({1'b0, dec} > cur.speed) ? '0 : (cur.speed - {1'b0, dec});
        end

        nxt.speed         = spd;
        nxt.last_distance = distance;
        nxt.safe_count    = cnt;
        nxt.seen_first    = 1'b1;

        res.speed_pwm     = spd;
        res.stopped       = stop;
        res.speed_changed = (spd != cur.speed);
        if ((spd >= REPORT_MIN) && (spd <= cfg.speed_cap)) begin
            res.reported_speed = spd;
        end else if (spd >= cfg.speed_cap) begin
            res.reported_speed = cfg.speed_cap;
        end else begin
            res.reported_speed = REPORT_MIN;
        end
    end

endmodule

[bench/dcsc_checker.sv]
// Scoreboard for the distance cruise speed control block: predicts and checks every result beat.
`timescale 1ns / 1ps

module dcsc_checker
    import dcsc_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [S_DATA_W-1:0]   s_tdata,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [M_DATA_W-1:0]   m_tdata,
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int unsigned           errors,
    output int unsigned           pending
);

    cfg_t        cfg;
    ctl_state_t  ctl;
    result_t     speed_results[$];
    int unsigned mismatches = 0;

    // Advance the speed state by one distance sample and return the result beat it yields.
    task automatic update_speed(input logic [DIST_W-1:0] sample, output result_t res);
        int spd;
        int step;
        int drop;
        res = '0;
        spd = int'(ctl.speed);
        if (sample <= cfg.dead_distance) begin
            spd = 0;
            res.stopped = 1'b1;
        end else if (sample >= cfg.safe_dist) begin
            ctl.safe_count = ctl.safe_count + 1'b1;
            if (ctl.safe_count > SAFE_LIMIT) begin
                ctl.safe_count = '0;
                if (spd < int'(cfg.speed_cap)) begin
                    spd = spd + int'(RAMP_INC);
                    if (spd > int'(SPEED_SAT)) begin
                        spd = int'(SPEED_SAT);
                    end
                end else begin
                    spd = int'(cfg.speed_cap);
                end
            end
        end else begin
            step = (int'(cfg.safe_dist) - int'(sample) + StepCm - 1) / StepCm;
            drop = (ctl.seen_first && sample > ctl.last_distance) ? 2 * step : 3 * step;
            spd  = (drop > spd) ? 0 : spd - drop;
        end
        res.speed_changed = (SPEED_W'(spd) != ctl.speed);
        res.speed_pwm     = SPEED_W'(spd);
        ctl.speed         = SPEED_W'(spd);
        ctl.last_distance = sample;
        ctl.seen_first    = 1'b1;
        if (ctl.speed >= REPORT_MIN && ctl.speed <= cfg.speed_cap) begin
            res.reported_speed = ctl.speed;
        end else if (ctl.speed >= cfg.speed_cap) begin
            res.reported_speed = cfg.speed_cap;
        end else begin
            res.reported_speed = REPORT_MIN;
        end
    endtask

    task automatic compare_field(input string field, input int want, input int got);
        if (want != got) begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
        end
    endtask

    always @(posedge aclk) begin
        result_t want;
        result_t got;
        if (!aresetn) begin
            cfg.safe_dist     = SAFE_DIST_RST;
            cfg.speed_cap     = MAX_SPEED_RST;
            cfg.dead_distance = DEAD_DIST_RST;
            ctl = '0;
            speed_results.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                got = result_t'(m_tdata);
                if (speed_results.size() == 0) begin
                    mismatches++;
                    $display("%0t: result beat with nothing outstanding, expected none, actual %h",
                             $time, m_tdata);
                end else begin
                    want = speed_results.pop_front();
                    compare_field("speed_pwm", want.speed_pwm, got.speed_pwm);
                    compare_field("stopped", want.stopped, got.stopped);
                    compare_field("speed_changed", want.speed_changed, got.speed_changed);
                    compare_field("reported_speed", want.reported_speed, got.reported_speed);
                end
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_idx_t'(cfg_index))
                    REG_SAFE_DIST: cfg.safe_dist     = cfg_data[SPEED_W-1:0];
                    REG_MAX_SPEED: cfg.speed_cap     = cfg_data[SPEED_W-1:0];
                    REG_DEAD_DIST: cfg.dead_distance = cfg_data[SPEED_W-1:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                update_speed(s_tdata[DIST_W-1:0], want);
                speed_results.push_back(want);
            end
        end
        errors  <= mismatches;
        pending <= speed_results.size();
    end

endmodule

[bench/tb.sv]
// Top-level testbench for distance cruise speed control: stimulus, watchdog and verdict.
`timescale 1ns / 1ps

module tb;
    import dcsc_pkg::*;

    // Cycles with no beat on any channel before the run is declared hung.
    localparam int STALL_LIMIT = 2000;
    localparam int PHASE_ITEMS = 100;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic [S_DATA_W-1:0]   s_tdata   = '0;
    logic                  m_tready  = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = REG_SAFE_DIST;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  s_tready;
    logic                  m_tvalid;
    logic [M_DATA_W-1:0]   m_tdata;
    logic                  cfg_ready;

    int unsigned fail_count;
    int unsigned results_due;
    int          stall_cycles = 0;
    bit          quiet        = 1'b0;   // when set, neither side idles

    // Register values as last written, used to aim the distance samples at each zone.
    int cur_safe = SAFE_DIST_RST;
    int cur_max  = MAX_SPEED_RST;
    int cur_dead = DEAD_DIST_RST;

    distance_cruise_speed_control uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    dcsc_checker scoreboard (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .errors    (fail_count),
        .pending   (results_due)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Stall the result side about 12 percent of the time, except during the quiet stretch.
    always @(posedge aclk) begin
        m_tready <= quiet || ($urandom_range(99) >= 12);
    end

    // Count cycles with no beat anywhere; give up when the block stops moving.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)
                || (cfg_valid && cfg_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("status: fail");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // Present one distance beat and hold it until the block takes it.
    // Drop valid first, now and then, so gaps land on every phase.
    task automatic send_distance(input int dist_cm);
        if (!quiet && $urandom_range(99) < 12) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= S_DATA_W'(DIST_W'(dist_cm));
        do @(posedge aclk); while (!s_tready);
    endtask

    // Hold off the sender until every outstanding result beat has come back.
    // The first edge lets the scoreboard count a beat taken on the last one.
    task automatic drain();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (results_due != 0);
    endtask

    // Put one register write on the config channel; the top data bit is junk the block drops.
    task automatic write_reg(input cfg_idx_t idx, input int value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= {1'($urandom_range(0, 1)), 7'(value)};
        do @(posedge aclk); while (!cfg_ready);
    endtask

    // Reprogram all three thresholds with the block idle; also poke the spare index.
    task automatic set_thresholds(input int safe_cm, input int max_pwm, input int dead_cm);
        drain();
        write_reg(REG_UNUSED, $urandom_range(0, 127));
        write_reg(REG_SAFE_DIST, safe_cm);
        write_reg(REG_MAX_SPEED, max_pwm);
        write_reg(REG_DEAD_DIST, dead_cm);
        cfg_valid <= 1'b0;
        cur_safe = safe_cm;
        cur_max  = max_pwm;
        cur_dead = dead_cm;
    endtask

    // Drive mostly well-formed drives: runs of safe samples long enough to ramp,
    // approach and retreat runs between the zones, stops, and some pure noise.
    task automatic drive_traffic(input int count);
        int sent;
        int mode;
        int run_len;
        int sample_cm;
        int lo;
        int hi;
        bit receding;
        sent = 0;
        while (sent < count) begin
            mode = $urandom_range(99);
            if (mode < 45) begin
                run_len = $urandom_range(1, 14);
                repeat (run_len) begin
                    if ($urandom_range(0, 1))
                        sample_cm = $urandom_range(cur_safe, cur_safe + 20);
                    else
                        sample_cm = $urandom_range(cur_safe, 1023);
                    send_distance(sample_cm);
                    sent++;
                end
            end else if (mode < 80 && cur_safe > cur_dead + 1) begin
                lo        = cur_dead + 1;
                hi        = cur_safe - 1;
                sample_cm = $urandom_range(lo, hi);
                receding  = $urandom_range(0, 1);
                run_len   = $urandom_range(1, 5);
                repeat (run_len) begin
                    send_distance(sample_cm);
                    sent++;
                    sample_cm = receding ? sample_cm + $urandom_range(0, 6)
                                         : sample_cm - $urandom_range(0, 6);
                    if (sample_cm < lo) sample_cm = lo;
                    if (sample_cm > hi) sample_cm = hi;
                end
            end else if (mode < 90) begin
                send_distance($urandom_range(0, cur_dead));
                sent++;
            end else begin
                send_distance($urandom_range(0, 1023));
                sent++;
            end
        end
    endtask

    initial begin
        // First sample sits between zones with no history, then a stop, two ramps,
        // approach and retreat steps, both dead-zone edges and the field extremes.
        int directed [] = '{30, 0, 55, 55, 55, 55, 55, 55,
                            1023, 1023, 1023, 1023, 1023, 1023,
                            40, 45, 54, 11, 10, 512, 341, 682};
        int safe_cm;

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed[i]) send_distance(directed[i]);

        // Register defaults again, with a full hold-off halfway through.
        set_thresholds(55, 80, 10);
        drive_traffic(PHASE_ITEMS / 2);
        drain();
        drive_traffic(PHASE_ITEMS / 2);

        // Lowest safe distance, lowest max speed, no dead zone but zero.
        set_thresholds(10, 45, 0);
        drive_traffic(PHASE_ITEMS);

        // Dead zone swallows everything up to the safe distance: stop wins.
        set_thresholds(95, 100, 100);
        drive_traffic(PHASE_ITEMS);

        // Max speed past its range: a long safe run ramps the speed into saturation.
        set_thresholds(95, 127, 5);
        repeat (60) send_distance($urandom_range(95, 1023));
        drive_traffic(PHASE_ITEMS);

        // Max speed below the display floor: ramps overshoot and the report clamps.
        set_thresholds(30, 8, 3);
        drive_traffic(PHASE_ITEMS);

        // Random thresholds inside their ranges; the middle phase runs without idling.
        for (int phase = 0; phase < 3; phase++) begin
            safe_cm = $urandom_range(10, 95);
            set_thresholds(safe_cm, $urandom_range(45, 100), $urandom_range(0, safe_cm - 1));
            quiet = (phase == 1);
            drive_traffic(PHASE_ITEMS);
        end
        quiet = 1'b0;

        drain();
        repeat (4) @(posedge aclk);
        if (fail_count == 0 && results_due == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
